@@ sv/fnv1a_linear_probe_hash_map_assert.svh @@
// Assertion macros for the hash map RTL.
// Relies on signals named clk and rst in the module that expands them.
`ifndef FNV1A_LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`define FNV1A_LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define FNVHM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define FNVHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FNVHM_ASSERT_IMP(lbl, ante, cons, msg)
`define FNVHM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/fnvhm_pkg.sv @@
// Shared types, codes and the FNV-1a step for the hash map.
// No dependencies.
package fnvhm_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

  localparam logic FUNC_SET = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_INSERTED = 2'd1;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  typedef struct packed {
    logic        func;
    logic [63:0] key_bytes;
    logic [3:0]  key_len;
    logic [31:0] value_in;
  } fnvhm_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [8:0]  entry_total;
  } fnvhm_rsp_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic hash_step;
    logic probe_adv;
    logic commit;
    logic out_load;
  } fnvhm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic probe_end;
    logic out_free;
  } fnvhm_sts_t;

  // One FNV-1a round: xor in the byte, then multiply by the prime 2^40 + 0x1B3,
  // written out as a sum of shifted copies.
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

@@ sv/fnvhm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fnvhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/fnvhm_ctrl.sv @@
// Sequencer for the hash map: clear pass, hashing, probing, result hand-off.
// Depends on fnvhm_pkg.
module fnvhm_ctrl import fnvhm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  fnvhm_sts_t sts,
  output fnvhm_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_HASH   = 6'b000100,
    ST_LOOK   = 6'b001000,
    ST_CHECK  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.probe_end) begin
          cmd.commit = 1'b1;
          state_next = ST_FINISH;
        end else begin
          cmd.probe_adv = 1'b1;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign req_stall = (state != ST_IDLE);

endmodule

@@ sv/fnvhm_dp.sv @@
// Datapath for the hash map: key capture, FNV-1a hashing, probe address,
// slot compare, occupancy count and the result register.
// Depends on fnvhm_pkg and the assertion macro header.
`include "fnv1a_linear_probe_hash_map_assert.svh"
module fnvhm_dp import fnvhm_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_WIDTH = 32,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int KW = 8 * KEY_BYTES,
  localparam int LW = $clog2(KEY_BYTES + 1),
  localparam int MW = 1 + LW + KW + VALUE_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  fnvhm_cmd_t    cmd,
  output fnvhm_sts_t    sts,
  input  fnvhm_req_t    req,
  output fnvhm_rsp_t    rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [MW-1:0] mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [MW-1:0] mem_rdata
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                   func;
  logic [KW-1:0]          key;
  logic [LW-1:0]          len;
  logic [VALUE_WIDTH-1:0] val;
  logic [63:0]            h;
  logic [KW-1:0]          hb;
  logic [LW-1:0]          rem;
  logic [AW-1:0]          idx;
  logic [AW-1:0]          n;
  logic [CW-1:0]          count;
  logic [1:0]             res_status;
  logic [VALUE_WIDTH-1:0] res_value;

  logic [3:0]             len_norm;
  logic [KW-1:0]          key_m;
  logic [63:0]            val64;
  logic [63:0]            h_next;
  logic                   rd_valid;
  logic [LW-1:0]          rd_len;
  logic [KW-1:0]          rd_key;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic                   hit;
  logic                   exhausted;
  logic                   write_ok;
  logic                   insert;
  logic [1:0]             status_c;
  logic [63:0]            vo64;
  logic [31:0]            cnt32;

  // Normalise the length and drop bytes above it.
  always_comb begin
    if (req.key_len == 4'd0) begin
      len_norm = 4'd1;
    end else if (req.key_len > 4'(KEY_BYTES)) begin
      len_norm = 4'(KEY_BYTES);
    end else begin
      len_norm = req.key_len;
    end
    for (int i = 0; i < KEY_BYTES; i++) begin
      key_m[8*i +: 8] = (4'(i) < len_norm) ? req.key_bytes[8*i +: 8] : 8'd0;
    end
  end

  assign val64  = {32'd0, req.value_in};
  assign h_next = fnv_step(h, hb[7:0]);

  assign rd_value = mem_rdata[VALUE_WIDTH-1:0];
  assign rd_key   = mem_rdata[VALUE_WIDTH +: KW];
  assign rd_len   = mem_rdata[VALUE_WIDTH+KW +: LW];
  assign rd_valid = mem_rdata[MW-1];

  assign hit       = rd_valid && (rd_len == len) && (rd_key == key);
  assign exhausted = (n == AW'(TABLE_DEPTH - 1));
  assign write_ok  = (func == FUNC_SET) && (hit || !rd_valid);
  assign insert    = (func == FUNC_SET) && !rd_valid;

  always_comb begin
    if (func == FUNC_SET) begin
      if (hit) begin
        status_c = STATUS_FOUND;
      end else if (!rd_valid) begin
        status_c = STATUS_INSERTED;
      end else begin
        status_c = STATUS_FULL;
      end
    end else begin
      status_c = hit ? STATUS_FOUND : STATUS_NOTFOUND;
    end
  end

  assign sts.clr_last  = (idx == AW'(TABLE_DEPTH - 1));
  assign sts.hash_last = (rem == LW'(1));
  assign sts.probe_end = !rd_valid || hit || exhausted;
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  assign mem_we    = cmd.clr_step || (cmd.commit && write_ok);
  assign mem_waddr = idx;
  assign mem_wdata = cmd.clr_step ? '0 : {1'b1, len, key, val};
  // Issue the next slot's read while the current one is compared.
  assign mem_raddr = cmd.probe_adv ? idx + AW'(1) : idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= req.func;
      key  <= key_m;
      len  <= len_norm[LW-1:0];
      val  <= val64[VALUE_WIDTH-1:0];
      h    <= FNV_BASIS;
      hb   <= key_m;
      rem  <= len_norm[LW-1:0];
    end else if (cmd.hash_step) begin
      h   <= h_next;
      hb  <= hb >> 8;
      rem <= rem - LW'(1);
    end
    if (cmd.hash_step && sts.hash_last) begin
      n <= '0;
    end else if (cmd.probe_adv) begin
      n <= n + AW'(1);
    end
    if (cmd.commit) begin
      res_status <= status_c;
      res_value  <= (func == FUNC_GET && hit) ? rd_value : '0;
    end
  end

  // Slot index doubles as the clear-pass counter after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.clr_step || cmd.probe_adv) begin
      idx <= idx + AW'(1);
    end else if (cmd.hash_step && sts.hash_last) begin
      idx <= h_next[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit && insert) begin
      count <= count + CW'(1);
    end
  end

  assign vo64  = 64'(res_value);
  assign cnt32 = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status      <= res_status;
      rsp.value_out   <= vo64[31:0];
      rsp.entry_total <= cnt32[8:0];
    end
  end

  `FNVHM_ASSERT_NXT(a_insert_counts, cmd.commit && insert,
                    count == $past(count) + CW'(1), "insert did not bump the occupancy count")
  `FNVHM_ASSERT_IMP(a_load_when_free, cmd.out_load,
                    !rsp_valid || !rsp_stall, "result loaded over an unaccepted item")
  `FNVHM_ASSERT_IMP(a_no_adv_at_end, cmd.probe_adv,
                    !sts.probe_end, "probe advanced past a terminating slot")

endmodule

@@ sv/fnv1a_linear_probe_hash_map.sv @@
// Key/value store using open addressing with linear probing over a 64-bit FNV-1a hash.
// Each request is a set or a get on a key of 1 to KEY_BYTES bytes; one result item comes
// back per request. After reset a clearing pass writes every slot, and requests stall
// until it ends. A request then runs through these steps from acceptance to the next
// acceptance, key_len being the length after clamping to 1..KEY_BYTES: one hash step
// per key byte through the single FNV-1a xor-multiply round, a read of the home slot,
// P probe steps (1 to TABLE_DEPTH, one slot per cycle through the RAM's registered
// read port), the hand-over of the result and the idle state in which the next
// request is taken. The hand-over waits for as long as the previous result is held
// by rsp_stall.
// Depends on fnvhm_pkg, fnvhm_ctrl, fnvhm_dp and fnvhm_ram.
module fnv1a_linear_probe_hash_map import fnvhm_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  fnvhm_req_t req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output fnvhm_rsp_t rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int MW = 1 + $clog2(KEY_BYTES + 1) + 8 * KEY_BYTES + VALUE_WIDTH;

  fnvhm_cmd_t    cmd;
  fnvhm_sts_t    sts;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;

  fnvhm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fnvhm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  fnvhm_ram #(
    .WIDTH (MW),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
